// File: rtl/circle_collision_push_vector_core_macros.svh
// ----------------------------------------------------------------------------
// Circle collision push vector: assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_COLLISION_PUSH_VECTOR_CORE_MACROS_SVH
`define CIRCLE_COLLISION_PUSH_VECTOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCPV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccpv: same-cycle check failed");

// next-cycle implication, disabled during reset
`define CCPV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccpv: next-cycle check failed");

`endif

// File: rtl/ccpv_pkg.sv
// ----------------------------------------------------------------------------
// Circle collision push vector: package
// Operation codes and the control group that travels down the pipeline.
// ----------------------------------------------------------------------------
package ccpv_pkg;

   typedef enum logic [1:0] {
      OP_CIRCLE_BOX    = 2'd0,
      OP_CIRCLE_CIRCLE = 2'd1,
      OP_BOX_CIRCLE    = 2'd2
   } op_type;

   typedef struct packed {
      logic valid;
      logic hit;
      logic neg;
   } ctl_type;

endpackage

// File: rtl/ccpv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Circle collision push vector: square root cell
// One restoring step of the integer square root; a row of these settles
// one root bit per cell while the side payload moves along with it.
// ----------------------------------------------------------------------------
module ccpv_sqrt_cell #(
   parameter int ROOT_W = 25,
   parameter int SIDE_W = 78
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ccpv_pkg::ctl_type     ctl_in,
   input  logic [2*ROOT_W-1:0]   s_in,
   input  logic [ROOT_W:0]       rem_in,
   input  logic [ROOT_W-1:0]     root_in,
   input  logic [SIDE_W-1:0]     side_in,
   output ccpv_pkg::ctl_type     ctl_out,
   output logic [2*ROOT_W-1:0]   s_out,
   output logic [ROOT_W:0]       rem_out,
   output logic [ROOT_W-1:0]     root_out,
   output logic [SIDE_W-1:0]     side_out
);

   localparam int SW = 2 * ROOT_W;

   ccpv_pkg::ctl_type     ctl_ff;
   logic [SW-1:0]         s_ff, s_in_nx;
   logic [ROOT_W:0]       rem_ff, rem_in_nx;
   logic [ROOT_W-1:0]     root_ff, root_in_nx;
   logic [SIDE_W-1:0]     side_ff;
   logic [ROOT_W+1:0]     pre, trial;

   always_comb begin
      // bring down the next two radicand bits and try root*4+1
      pre        = {rem_in[ROOT_W-1:0], s_in[SW-1 -: 2]};
      trial      = {root_in, 2'b01};
      s_in_nx    = {s_in[SW-3:0], 2'b00};
      if (pre >= trial) begin
         rem_in_nx  = (ROOT_W+1)'(pre - trial);
         root_in_nx = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in_nx  = (ROOT_W+1)'(pre);
         root_in_nx = {root_in[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff    <= s_in_nx;
         rem_ff  <= rem_in_nx;
         root_ff <= root_in_nx;
         side_ff <= side_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign s_out    = s_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;

endmodule

// File: rtl/ccpv_div_cell.sv
// ----------------------------------------------------------------------------
// Circle collision push vector: divider cell
// One restoring division step for the x and y lanes against a shared
// divisor; the dividend shifts out at the top as quotient bits shift in.
// ----------------------------------------------------------------------------
module ccpv_div_cell #(
   parameter int DW     = 25,
   parameter int QW     = 25,
   parameter int SIDE_W = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  ccpv_pkg::ctl_type       ctl_in,
   input  logic [DW-1:0]           d_in,
   input  logic [1:0][DW-1:0]      rem_in,
   input  logic [1:0][QW-1:0]      mq_in,
   input  logic [SIDE_W-1:0]       side_in,
   output ccpv_pkg::ctl_type       ctl_out,
   output logic [DW-1:0]           d_out,
   output logic [1:0][DW-1:0]      rem_out,
   output logic [1:0][QW-1:0]      mq_out,
   output logic [SIDE_W-1:0]       side_out
);

   ccpv_pkg::ctl_type     ctl_ff;
   logic [DW-1:0]         d_ff;
   logic [1:0][DW-1:0]    rem_ff, rem_in_nx;
   logic [1:0][QW-1:0]    mq_ff, mq_in_nx;
   logic [SIDE_W-1:0]     side_ff;
   logic [1:0][DW:0]      pre;
   logic [1:0]            ge;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         pre[i] = {rem_in[i], mq_in[i][QW-1]};
         ge[i]  = (pre[i] >= {1'b0, d_in});
         if (ge[i]) begin
            rem_in_nx[i] = DW'(pre[i] - {1'b0, d_in});
         end else begin
            rem_in_nx[i] = DW'(pre[i]);
         end
         mq_in_nx[i] = {mq_in[i][QW-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff    <= d_in;
         rem_ff  <= rem_in_nx;
         mq_ff   <= mq_in_nx;
         side_ff <= side_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign d_out    = d_ff;
   assign rem_out  = rem_ff;
   assign mq_out   = mq_ff;
   assign side_out = side_ff;

endmodule

// File: rtl/circle_collision_push_vector_core.sv
// ----------------------------------------------------------------------------
// Circle collision push vector core
// Narrow-phase circle/box and circle/circle overlap test giving a saturated
// fixed-point push vector, one shape pair per transaction.
// ----------------------------------------------------------------------------
//   channel  ports   carries
//   request  req_*   operation, circle, shape p0..p3, fallback direction
//   response rsp_*   hit flag and push vector
//
// One transaction per cycle sustained while no response waits. The pipeline has
// three front stages, a row of COORD_WIDTH+1 square root cells, depth and
// product stages, a row of divider cells, rounding and the output register.
// The whole pipeline holds while a response waits; reset empties it.
module circle_collision_push_vector_core #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic signed [COORD_WIDTH-1:0] req_centre_x,
   input  logic signed [COORD_WIDTH-1:0] req_centre_y,
   input  logic [COORD_WIDTH-2:0]        req_radius,
   input  logic signed [COORD_WIDTH-1:0] req_shape_p0,
   input  logic signed [COORD_WIDTH-1:0] req_shape_p1,
   input  logic signed [COORD_WIDTH-1:0] req_shape_p2,
   input  logic signed [COORD_WIDTH-1:0] req_shape_p3,
   input  logic signed [COORD_WIDTH-1:0] req_fallback_x,
   input  logic signed [COORD_WIDTH-1:0] req_fallback_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_push_x,
   output logic signed [COORD_WIDTH-1:0] rsp_push_y
);

   localparam int W      = COORD_WIDTH;
   localparam int W1     = W + 1;
   localparam int SW     = 2 * W1;
   localparam int KW     = (W1 > FRAC_BITS + 1) ? W1 : FRAC_BITS + 1;
   localparam int MW     = W1 + KW;
   localparam int SQ_SIDE = 3 * W1 + 3;
   localparam logic [KW:0] POS_LIM = (KW+1)'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [KW:0] NEG_LIM = (KW+1)'(64'd1 << (W - 1));
   localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

   logic advance;

   // ---------------- front: clamp, offset, magnitude ----------------
   logic signed [W1-1:0] cx, cy, p0, p1, p2, p3, fx, fy;
   logic signed [W1-1:0] tx, ty, dx, dy, ex, ey, vx, vy;
   logic [W1-1:0]        rad, orad, rs, r_sel, ax, ay;
   logic                 box_zero, is_box, is_circ, neg;

   always_comb begin
      cx = {req_centre_x[W-1], req_centre_x};
      cy = {req_centre_y[W-1], req_centre_y};
      p0 = {req_shape_p0[W-1], req_shape_p0};
      p1 = {req_shape_p1[W-1], req_shape_p1};
      p2 = {req_shape_p2[W-1], req_shape_p2};
      p3 = {req_shape_p3[W-1], req_shape_p3};
      fx = {req_fallback_x[W-1], req_fallback_x};
      fy = {req_fallback_y[W-1], req_fallback_y};
      // left before right, top before bottom
      if (cx < p0) begin
         tx = p0;
      end else if (cx > p1) begin
         tx = p1;
      end else begin
         tx = cx;
      end
      if (cy < p2) begin
         ty = p2;
      end else if (cy > p3) begin
         ty = p3;
      end else begin
         ty = cy;
      end
      dx       = cx - tx;
      dy       = cy - ty;
      ex       = cx - p0;
      ey       = cy - p1;
      box_zero = (dx == '0) && (dy == '0);
      rad      = {2'b00, req_radius};
      orad     = req_shape_p2[W-1] ? '0 : {2'b00, req_shape_p2[W-2:0]};
      rs       = rad + orad;
      is_box   = 1'b0;
      is_circ  = 1'b0;
      neg      = 1'b0;
      vx       = '0;
      vy       = '0;
      r_sel    = rad;
      case (req_operation)
         ccpv_pkg::OP_CIRCLE_BOX, ccpv_pkg::OP_BOX_CIRCLE: begin
            is_box = 1'b1;
            neg    = (req_operation == ccpv_pkg::OP_BOX_CIRCLE);
            // centre on the box: push along the fallback direction
            vx     = box_zero ? fx : dx;
            vy     = box_zero ? fy : dy;
         end
         ccpv_pkg::OP_CIRCLE_CIRCLE: begin
            is_circ = 1'b1;
            vx      = ex;
            vy      = ey;
            r_sel   = rs;
         end
         default: begin
            is_box = 1'b0;
         end
      endcase
      ax = vx[W1-1] ? W1'(-vx) : W1'(vx);
      ay = vy[W1-1] ? W1'(-vy) : W1'(vy);
   end

   // ---------------- stage 1 ----------------
   ccpv_pkg::ctl_type s1_ctl_ff, s1_ctl_in;
   logic              s1_box_ff, s1_circ_ff, s1_zero_ff, s1_sx_ff, s1_sy_ff;
   logic [W1-1:0]     s1_ax_ff, s1_ay_ff, s1_r_ff;

   always_comb begin
      s1_ctl_in.valid = req_valid;
      s1_ctl_in.hit   = 1'b0;
      s1_ctl_in.neg   = neg;
   end

   // ---------------- stage 2: squares ----------------
   ccpv_pkg::ctl_type s2_ctl_ff;
   logic              s2_box_ff, s2_circ_ff, s2_zero_ff, s2_sx_ff, s2_sy_ff;
   logic [W1-1:0]     s2_ax_ff, s2_ay_ff, s2_r_ff;
   logic [SW-1:0]     s2_sqx_ff, s2_sqy_ff, s2_r2_ff;

   // ---------------- stage 3: sum and hit ----------------
   ccpv_pkg::ctl_type s3_ctl_ff, s3_ctl_in;
   logic [SW-1:0]     s3_s_ff, s3_s_in;
   logic [SQ_SIDE-1:0] s3_side_ff;

   always_comb begin
      s3_s_in         = s2_sqx_ff + s2_sqy_ff;
      s3_ctl_in.valid = s2_ctl_ff.valid;
      s3_ctl_in.neg   = s2_ctl_ff.neg;
      if (s2_box_ff) begin
         s3_ctl_in.hit = s2_zero_ff ? (s2_r_ff != '0) : (s3_s_in < s2_r2_ff);
      end else if (s2_circ_ff) begin
         s3_ctl_in.hit = (s3_s_in <= s2_r2_ff);
      end else begin
         s3_ctl_in.hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_box_ff  <= is_box;
         s1_circ_ff <= is_circ;
         // fallback direction applies to the box operations only
         s1_zero_ff <= box_zero && is_box;
         s1_sx_ff   <= vx[W1-1];
         s1_sy_ff   <= vy[W1-1];
         s1_ax_ff   <= ax;
         s1_ay_ff   <= ay;
         s1_r_ff    <= r_sel;
         s2_box_ff  <= s1_box_ff;
         s2_circ_ff <= s1_circ_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_sx_ff   <= s1_sx_ff;
         s2_sy_ff   <= s1_sy_ff;
         s2_ax_ff   <= s1_ax_ff;
         s2_ay_ff   <= s1_ay_ff;
         s2_r_ff    <= s1_r_ff;
         s2_sqx_ff  <= s1_ax_ff * s1_ax_ff;
         s2_sqy_ff  <= s1_ay_ff * s1_ay_ff;
         s2_r2_ff   <= s1_r_ff * s1_r_ff;
         s3_s_ff    <= s3_s_in;
         s3_side_ff <= {s2_r_ff, s2_ax_ff, s2_ay_ff, s2_sx_ff, s2_sy_ff, s2_zero_ff};
      end
   end

   // ---------------- square root row ----------------
   ccpv_pkg::ctl_type   sq_ctl  [0:W1];
   logic [SW-1:0]       sq_s    [0:W1-1];
   logic [W1:0]         sq_rem  [0:W1];
   logic [W1-1:0]       sq_root [0:W1];
   logic [SQ_SIDE-1:0]  sq_side [0:W1];

   assign sq_ctl[0]  = s3_ctl_ff;
   assign sq_s[0]    = s3_s_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = s3_side_ff;

   for (genvar g = 0; g < W1; g++) begin : g_sqrt
      if (g < W1 - 1) begin : g_mid
         ccpv_sqrt_cell #(.ROOT_W(W1), .SIDE_W(SQ_SIDE)) u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .ctl_in(sq_ctl[g]), .s_in(sq_s[g]), .rem_in(sq_rem[g]),
            .root_in(sq_root[g]), .side_in(sq_side[g]),
            .ctl_out(sq_ctl[g+1]), .s_out(sq_s[g+1]), .rem_out(sq_rem[g+1]),
            .root_out(sq_root[g+1]), .side_out(sq_side[g+1])
         );
      end else begin : g_last
         ccpv_sqrt_cell #(.ROOT_W(W1), .SIDE_W(SQ_SIDE)) u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .ctl_in(sq_ctl[g]), .s_in(sq_s[g]), .rem_in(sq_rem[g]),
            .root_in(sq_root[g]), .side_in(sq_side[g]),
            .ctl_out(sq_ctl[g+1]), .s_out(), .rem_out(sq_rem[g+1]),
            .root_out(sq_root[g+1]), .side_out(sq_side[g+1])
         );
      end
   end

   // ---------------- depth stage ----------------
   logic [W1-1:0]     sq_r, sq_ax, sq_ay;
   logic              sq_sx, sq_sy, sq_zero;
   logic [W1-1:0]     depth;
   ccpv_pkg::ctl_type sk_ctl_ff;
   logic [KW-1:0]     sk_k_ff, sk_k_in;
   logic [W1-1:0]     sk_d_ff, sk_ax_ff, sk_ay_ff;
   logic              sk_sx_ff, sk_sy_ff;

   always_comb begin
      {sq_r, sq_ax, sq_ay, sq_sx, sq_sy, sq_zero} = sq_side[W1];
      depth   = sq_r - sq_root[W1];
      sk_k_in = sq_zero ? (KW'(1) << FRAC_BITS) : KW'(depth);
   end

   // ---------------- product stage ----------------
   ccpv_pkg::ctl_type sm_ctl_ff;
   logic [MW-1:0]     sm_mx_ff, sm_my_ff;
   logic [W1-1:0]     sm_d_ff;
   logic              sm_sx_ff, sm_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sk_ctl_ff <= '0;
         sm_ctl_ff <= '0;
      end else if (advance) begin
         sk_ctl_ff <= sq_ctl[W1];
         sm_ctl_ff <= sk_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sk_k_ff  <= sk_k_in;
         sk_d_ff  <= sq_root[W1];
         sk_ax_ff <= sq_ax;
         sk_ay_ff <= sq_ay;
         sk_sx_ff <= sq_sx;
         sk_sy_ff <= sq_sy;
         sm_mx_ff <= sk_ax_ff * sk_k_ff;
         sm_my_ff <= sk_ay_ff * sk_k_ff;
         sm_d_ff  <= sk_d_ff;
         sm_sx_ff <= sk_sx_ff;
         sm_sy_ff <= sk_sy_ff;
      end
   end

   // ---------------- divider row ----------------
   ccpv_pkg::ctl_type   dv_ctl  [0:KW];
   logic [W1-1:0]       dv_d    [0:KW];
   logic [1:0][W1-1:0]  dv_rem  [0:KW];
   logic [1:0][KW-1:0]  dv_mq   [0:KW];
   logic [1:0]          dv_side [0:KW];

   // the offset never exceeds the distance, so the high part is below d
   assign dv_ctl[0]  = sm_ctl_ff;
   assign dv_d[0]    = sm_d_ff;
   assign dv_rem[0]  = {sm_my_ff[MW-1:KW], sm_mx_ff[MW-1:KW]};
   assign dv_mq[0]   = {sm_my_ff[KW-1:0], sm_mx_ff[KW-1:0]};
   assign dv_side[0] = {sm_sx_ff, sm_sy_ff};

   for (genvar g = 0; g < KW; g++) begin : g_div
      ccpv_div_cell #(.DW(W1), .QW(KW), .SIDE_W(2)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .ctl_in(dv_ctl[g]), .d_in(dv_d[g]), .rem_in(dv_rem[g]),
         .mq_in(dv_mq[g]), .side_in(dv_side[g]),
         .ctl_out(dv_ctl[g+1]), .d_out(dv_d[g+1]), .rem_out(dv_rem[g+1]),
         .mq_out(dv_mq[g+1]), .side_out(dv_side[g+1])
      );
   end

   // ---------------- rounding stage ----------------
   ccpv_pkg::ctl_type sr_ctl_ff;
   logic [1:0][KW:0]  sr_q_ff, sr_q_in;
   logic [1:0]        sr_sign_ff;
   logic              sr_dzero_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         // ties away from zero: bump when 2r >= d
         sr_q_in[i] = (KW+1)'(dv_mq[KW][i])
                    + (KW+1)'({dv_rem[KW][i], 1'b0} >= {1'b0, dv_d[KW]});
      end
   end

   // ---------------- output register ----------------
   logic          rsp_valid_ff, rsp_hit_ff;
   logic [W-1:0]  rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in;

   function automatic logic [W-1:0] sat_push(input logic [KW:0] q, input logic sgn);
      logic [KW:0] nq;
      nq = ~q + 1'b1;
      if (sgn) begin
         sat_push = (q > NEG_LIM) ? SAT_MIN : nq[W-1:0];
      end else begin
         sat_push = (q > POS_LIM) ? SAT_MAX : q[W-1:0];
      end
   endfunction

   always_comb begin
      if (!sr_ctl_ff.hit || sr_dzero_ff) begin
         rsp_x_in = '0;
         rsp_y_in = '0;
      end else begin
         rsp_x_in = sat_push(sr_q_ff[0], sr_sign_ff[1] ^ sr_ctl_ff.neg);
         rsp_y_in = sat_push(sr_q_ff[1], sr_sign_ff[0] ^ sr_ctl_ff.neg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         sr_ctl_ff    <= dv_ctl[KW];
         rsp_valid_ff <= sr_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sr_q_ff     <= sr_q_in;
         sr_sign_ff  <= dv_side[KW];
         sr_dzero_ff <= (dv_d[KW] == '0);
         rsp_hit_ff  <= sr_ctl_ff.hit;
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
      end
   end

   // hold every stage while a response waits
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = advance;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_push_x = rsp_x_ff;
   assign rsp_push_y = rsp_y_ff;

   // ---------------- assertions ----------------
`include "circle_collision_push_vector_core_macros.svh"

   `CCPV_ASSERT_IMPLY(a_miss_zero_push, clock, reset, rsp_valid && !rsp_hit, rsp_push_x == '0 && rsp_push_y == '0)
   `CCPV_ASSERT_IMPLY(a_sqrt_rem_bound, clock, reset, sq_ctl[W1].valid, sq_rem[W1] <= {sq_root[W1], 1'b0})
   `CCPV_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, s1_ctl_ff.valid)
   `CCPV_ASSERT_NEXT(a_stall_holds_front, clock, reset, !advance, $stable(s1_ctl_ff) && $stable(sr_ctl_ff))

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Circle collision push vector core testbench
// Streams circle/box and circle/circle pairs through the core with random
// request gaps and response stalls, and checks each response against a
// behavioral predictor of hit flag and saturated push vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int CW        = 24;
   localparam int FB        = 8;
   localparam int LATENCY   = 57;
   localparam int N_RANDOM  = 1130;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      logic [1:0]          operation;
      logic signed [CW-1:0] centre_x, centre_y;
      logic [CW-2:0]        radius;
      logic signed [CW-1:0] p0, p1, p2, p3, fallback_x, fallback_y;
   } pair_type;

   typedef struct {
      logic                 hit;
      logic signed [CW-1:0] push_x, push_y;
   } push_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_operation = '0;
   logic signed [CW-1:0] req_centre_x = '0, req_centre_y = '0;
   logic [CW-2:0]        req_radius = '0;
   logic signed [CW-1:0] req_shape_p0 = '0, req_shape_p1 = '0;
   logic signed [CW-1:0] req_shape_p2 = '0, req_shape_p3 = '0;
   logic signed [CW-1:0] req_fallback_x = '0, req_fallback_y = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic signed [CW-1:0] rsp_push_x, rsp_push_y;

   pair_type pending_pairs[$];
   push_type expected_pushes[$];
   int    cycle_count = 0;
   int    error_count = 0;
   int    hit_count = 0;
   int    sent_count = 0;
   int    req_gap = 0;
   int    rsp_gap = 0;
   bit    req_taken = 1'b0;
   bit    rsp_taken = 1'b0;
   bit    stimulus_done = 1'b0;

   circle_collision_push_vector_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_operation,
      .req_centre_x, .req_centre_y, .req_radius,
      .req_shape_p0, .req_shape_p1, .req_shape_p2, .req_shape_p3,
      .req_fallback_x, .req_fallback_y,
      .rsp_valid, .rsp_ready, .rsp_hit, .rsp_push_x, .rsp_push_y
   );

   always #10 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // sign(c) * round(|c| * k / d), ties away from zero
   function automatic longint scale_round(longint c, longint unsigned k,
                                          longint unsigned d);
      longint unsigned m, q, r;
      m = (c < 0 ? -c : c) * k;
      q = m / d;
      r = m % d;
      if (r >= d - r) q++;
      return c < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [CW-1:0] saturate(longint v);
      longint hi;
      hi = (64'sd1 <<< (CW - 1)) - 1;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v[CW-1:0];
   endfunction

   function automatic push_type predict_push(pair_type p);
      push_type res;
      longint x, y, tx, ty, dx, dy, px, py, fx, fy, orad;
      longint unsigned rad, ax, ay, s, d, n, rs;
      logic   hit;
      x = p.centre_x;
      y = p.centre_y;
      rad = p.radius;
      px = 0;
      py = 0;
      hit = 1'b0;
      if (p.operation == ccpv_pkg::OP_CIRCLE_BOX || p.operation == ccpv_pkg::OP_BOX_CIRCLE) begin
         tx = x;
         ty = y;
         // left before right, top before bottom
         if (x < longint'(p.p0)) tx = p.p0;
         else if (x > longint'(p.p1)) tx = p.p1;
         if (y < longint'(p.p2)) ty = p.p2;
         else if (y > longint'(p.p3)) ty = p.p3;
         dx = x - tx;
         dy = y - ty;
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         if (ax < rad && ay < rad) begin
            s = ax * ax + ay * ay;
            if (s < rad * rad) begin
               hit = 1'b1;
               if (s == 0) begin
                  fx = p.fallback_x;
                  fy = p.fallback_y;
                  n = int_sqrt(fx * fx + fy * fy);
                  if (n != 0) begin
                     px = scale_round(fx, 64'd1 << FB, n);
                     py = scale_round(fy, 64'd1 << FB, n);
                  end
               end else begin
                  d = int_sqrt(s);
                  px = scale_round(dx, rad - d, d);
                  py = scale_round(dy, rad - d, d);
               end
            end
         end
         if (hit && p.operation == ccpv_pkg::OP_BOX_CIRCLE) begin
            px = -px;
            py = -py;
         end
      end else if (p.operation == ccpv_pkg::OP_CIRCLE_CIRCLE) begin
         orad = p.p2;
         rs = rad + (orad < 0 ? 0 : orad);
         dx = x - longint'(p.p0);
         dy = y - longint'(p.p1);
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         if (ax <= rs && ay <= rs && ax * ax <= rs * rs - ay * ay) begin
            hit = 1'b1;
            s = ax * ax + ay * ay;
            if (s != 0) begin
               d = int_sqrt(s);
               px = scale_round(dx, rs - d, d);
               py = scale_round(dy, rs - d, d);
            end
         end
      end
      res.hit = hit;
      res.push_x = saturate(px);
      res.push_y = saturate(py);
      return res;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         1, 2: return CW'($signed(CW'($urandom_range(0, 4000))) - 2000);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic int gap_length();
      case ($urandom_range(0, 19))
         0: return $urandom_range(10, 40);
         1, 2, 3, 4, 5, 6: return $urandom_range(1, 3);
         default: return 0;
      endcase
   endfunction

   function automatic pair_type make_pair(logic [1:0] op, longint cx, longint cy, longint r,
                                          longint a, longint b, longint c, longint e,
                                          longint fx, longint fy);
      pair_type p;
      p.operation = op;
      p.centre_x = CW'(cx); p.centre_y = CW'(cy); p.radius = (CW-1)'(r);
      p.p0 = CW'(a); p.p1 = CW'(b); p.p2 = CW'(c); p.p3 = CW'(e);
      p.fallback_x = CW'(fx); p.fallback_y = CW'(fy);
      return p;
   endfunction

   // well-formed pair near overlap with random content, or pure noise
   function automatic pair_type random_pair();
      pair_type p;
      longint cx, cy, w, h;
      p.operation = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) begin
         p.centre_x = CW'($urandom); p.centre_y = CW'($urandom);
         p.radius = (CW-1)'($urandom);
         p.p0 = CW'($urandom); p.p1 = CW'($urandom);
         p.p2 = CW'($urandom); p.p3 = CW'($urandom);
      end else begin
         cx = rand_coord();
         cy = rand_coord();
         w = $urandom_range(0, 3000);
         h = $urandom_range(0, 3000);
         p.radius = $urandom_range(0, 3) == 0 ? (CW-1)'($urandom)
                                              : (CW-1)'($urandom_range(0, 3000));
         p.centre_x = CW'(cx + longint'($urandom_range(0, 8000)) - 4000);
         p.centre_y = CW'(cy + longint'($urandom_range(0, 8000)) - 4000);
         p.p0 = CW'(cx);
         p.p1 = p.operation == ccpv_pkg::OP_CIRCLE_CIRCLE ? CW'(cy) : CW'(cx + w);
         p.p2 = p.operation == ccpv_pkg::OP_CIRCLE_CIRCLE
                ? CW'(rand_coord() >>> $urandom_range(0, 12)) : CW'(cy);
         p.p3 = CW'(cy + h);
         if ($urandom_range(0, 7) == 0) begin
            p.centre_x = CW'(cx + w / 2);
            p.centre_y = CW'(cy + h / 2);
         end
      end
      p.fallback_x = $urandom_range(0, 7) == 0 ? '0 : rand_coord();
      p.fallback_y = $urandom_range(0, 7) == 0 ? '0 : rand_coord();
      return p;
   endfunction

   initial begin
      localparam longint MAXC = (64'sd1 <<< (CW - 1)) - 1;
      localparam longint MINC = -MAXC - 1;
      localparam longint MAXR = (64'sd1 << (CW - 1)) - 1;
      // box hit with offset, centre inside box, zero fallback, inverted box
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_BOX, 0, 0, 1000, 300, 900, -50, 50,
                                        5, 5));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_BOX, 10, 10, 500, 0, 100, 0, 100,
                                        3, -4));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_BOX, 10, 10, 500, 0, 100, 0, 100,
                                        0, 0));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_BOX, 0, 0, 500, 100, -100, 100,
                                        -100, 1, 0));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_BOX_CIRCLE, 0, 0, 1000, 300, 900, -50, 50,
                                        5, 5));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_BOX_CIRCLE, 10, 10, 500, 0, 100, 0, 100,
                                        MINC, MAXC));
      // touching exactly at the radius: box misses, circles hit
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_BOX, 0, 0, 256, 256, 512, -10, 10,
                                        0, 0));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_CIRCLE, 0, 0, 256, 512, 0, 256, 0,
                                        0, 0));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_CIRCLE, 0, 0, 600, 300, 400, 200, 0,
                                        0, 0));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_CIRCLE, 5, 5, 100, 5, 5, 100, 0,
                                        0, 0));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_CIRCLE, 0, 0, 100, 150, 0, -500, 0,
                                        0, 0));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_CIRCLE, 0, 0, 100, 50, 0, -500, -1,
                                        0, 0));
      pending_pairs.push_back(make_pair(2'd3, 0, 0, 1000, 0, 0, 1000, 0, 1, 1));
      // extremes: saturation and full-range coordinates
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_CIRCLE, MAXC, MAXC, MAXR, MINC,
                                        MINC, MAXC, MAXC, MAXC, MINC));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_CIRCLE, MINC, MAXC, MAXR, MAXC,
                                        MINC, MINC, MINC, MINC, MAXC));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_BOX, MAXC, MINC, MAXR, MINC, MINC,
                                        MAXC, MAXC, 0, 0));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_BOX_CIRCLE, MINC, MINC, MAXR, 1, MAXC,
                                        1, MAXC, MAXC, MAXC));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_BOX, 0, 0, MAXR, MINC, MAXC,
                                        MINC, MAXC, MINC, MINC));
      pending_pairs.push_back(make_pair(ccpv_pkg::OP_CIRCLE_BOX, 1, 1, 0, 0, 0, 0, 0, 1, 1));
      for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(random_pair());
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // record the handshakes seen at the rising edge for the driver
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      rsp_taken <= rsp_valid && rsp_ready;
   end

   // request driver: hold each transaction until accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken || !req_valid) begin
            if (req_taken) req_gap = gap_length();
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               pair_type p;
               p = pending_pairs.pop_front();
               req_valid <= 1'b1;
               req_operation <= p.operation;
               req_centre_x <= p.centre_x;
               req_centre_y <= p.centre_y;
               req_radius <= p.radius;
               req_shape_p0 <= p.p0;
               req_shape_p1 <= p.p1;
               req_shape_p2 <= p.p2;
               req_shape_p3 <= p.p3;
               req_fallback_x <= p.fallback_x;
               req_fallback_y <= p.fallback_y;
            end else begin
               req_valid <= 1'b0;
               stimulus_done = 1'b1;
            end
         end
         // response side: stall for a random gap after each transaction
         if (rsp_taken) rsp_gap = gap_length();
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pair_type p;
            p.operation = req_operation;
            p.centre_x = req_centre_x; p.centre_y = req_centre_y;
            p.radius = req_radius;
            p.p0 = req_shape_p0; p.p1 = req_shape_p1;
            p.p2 = req_shape_p2; p.p3 = req_shape_p3;
            p.fallback_x = req_fallback_x; p.fallback_y = req_fallback_y;
            expected_pushes.push_back(predict_push(p));
            sent_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pushes.size() == 0) begin
               $error("unexpected response transaction");
               error_count++;
            end else begin
               push_type e;
               e = expected_pushes.pop_front();
               hit_count += e.hit;
               if (rsp_hit !== e.hit) begin
                  $error("hit: expected %0d, got %0d", e.hit, rsp_hit);
                  error_count++;
               end
               if (rsp_push_x !== e.push_x) begin
                  $error("push_x: expected %0d, got %0d", e.push_x, rsp_push_x);
                  error_count++;
               end
               if (rsp_push_y !== e.push_y) begin
                  $error("push_y: expected %0d, got %0d", e.push_y, rsp_push_y);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      wait (stimulus_done && !req_valid && expected_pushes.size() == 0
            || cycle_count >= MAX_CYCLE);
      if (cycle_count >= MAX_CYCLE) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         repeat (LATENCY + 10) @(posedge clock);
         if (expected_pushes.size() != 0) error_count++;
         $display("Sent %0d shape pairs, %0d responses were hits; %0d mismatches.",
                  sent_count, hit_count, error_count);
         if (error_count == 0) begin
            $display("*** PASSED ***");
         end else begin
            $display("*** FAILED ***");
         end
         $finish;
      end
   end
endmodule

// File: circle_collision_push_vector_core.f
+incdir+rtl
rtl/ccpv_pkg.sv
rtl/ccpv_sqrt_cell.sv
rtl/ccpv_div_cell.sv
rtl/circle_collision_push_vector_core.sv
test/tb.sv
